// File: rtl/u8sd_pkg.sv
// Shared types, constants and byte classification for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 2;

	localparam logic [20:0] CP_MIN2      = 21'h000080;
	localparam logic [20:0] CP_MIN3      = 21'h000800;
	localparam logic [20:0] CP_MIN4      = 21'h010000;
	localparam logic [20:0] CP_LIMIT     = 21'h110000;
	localparam logic [20:0] SURR_LO      = 21'h00d800;
	localparam logic [20:0] SURR_END     = 21'h00e000;
	localparam logic [20:0] NONCHAR_LO   = 21'h00fdd0;
	localparam logic [20:0] NONCHAR_HI   = 21'h00fdef;
	localparam logic [20:0] NONCHAR_MASK = 21'h00fffe;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_error;
		logic [2:0]  byte_length;
		logic        last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] len;
	} byte_info_t;

	typedef struct packed {
		byte_info_t b;
		logic       eos;
	} cls_word_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] n;
		n = LEN_NONE;
		if (b[7] == 1'b0) n = LEN_ONE;
		else if (b[7:5] == 3'b110) n = LEN_TWO;
		else if (b[7:4] == 4'b1110) n = LEN_THREE;
		else if (b[7:3] == 5'b11110) n = LEN_FOUR;
		return n;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

// File: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front queue, decoder engine, result queue.
// Path: a byte accepted into the front queue is decoded combinationally from the queue head,
// and its result is written into the result queue, which drives the result ports.
// Throughput: one byte per cycle while each byte causes at most one result and the result
// queue has room; a byte that causes more results holds the engine, one result per cycle.
// Reset: arst_n clears the queue pointers and counts and the engine state; buffered bytes are not cleared.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
	parameter int IN_DEPTH  = u8sd_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH = u8sd_pkg::OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  u8sd_pkg::in_word_t   item,
	input  logic                 pop,
	output logic                 empty,
	output u8sd_pkg::out_word_t  result
);

	logic                cls_pop;
	logic                cls_empty;
	u8sd_pkg::cls_word_t cls_word;
	logic                out_full;
	logic                out_push;
	u8sd_pkg::out_word_t out_word;

	u8sd_front #(
		.IN_DEPTH(IN_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cls_pop  (cls_pop),
		.cls_empty(cls_empty),
		.cls_word (cls_word)
	);

	u8sd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cls_empty(cls_empty),
		.cls_pop  (cls_pop),
		.cls_word (cls_word),
		.out_full (out_full),
		.out_push (out_push),
		.out_word (out_word)
	);

	u8sd_fifo #(
		.WIDTH($bits(u8sd_pkg::out_word_t)),
		.DEPTH(OUT_DEPTH)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.wdata (out_word),
		.pop   (pop),
		.empty (empty),
		.rdata (result)
	);

endmodule

// File: rtl/u8sd_fifo.sv
// Small register queue used for the byte and result words.
`timescale 1ns / 1ps

module u8sd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/u8sd_front.sv
// Front end: classify each incoming byte and queue it for the decoder engine.
`timescale 1ns / 1ps

module u8sd_front #(
	parameter int IN_DEPTH = u8sd_pkg::IN_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  u8sd_pkg::in_word_t   item,
	input  logic                 cls_pop,
	output logic                 cls_empty,
	output u8sd_pkg::cls_word_t  cls_word
);

	u8sd_pkg::cls_word_t cls_in;

	always_comb begin
		cls_in.b.data = item.data_byte;
		cls_in.b.len  = u8sd_pkg::lead_length(item.data_byte);
		cls_in.eos    = item.end_of_string;
	end

	u8sd_fifo #(
		.WIDTH($bits(u8sd_pkg::cls_word_t)),
		.DEPTH(IN_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cls_in),
		.pop   (cls_pop),
		.empty (cls_empty),
		.rdata (cls_word)
	);

endmodule

// File: rtl/u8sd_back.sv
// Decoder engine: holds the partial sequence and emits one result per cycle while the result queue has room.
`timescale 1ns / 1ps

module u8sd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cls_empty,
	output logic                 cls_pop,
	input  u8sd_pkg::cls_word_t  cls_word,
	input  logic                 out_full,
	output logic                 out_push,
	output u8sd_pkg::out_word_t  out_word
);

	u8sd_pkg::byte_info_t q_q [4];
	logic [2:0]           qn_q;
	logic                 end_q;
	logic                 busy_q;

	u8sd_pkg::byte_info_t w [4];
	u8sd_pkg::byte_info_t r [3];
	logic [2:0]           wn;
	logic                 wend;
	logic [2:0]           n;
	logic [2:0]           avail;
	logic                 bad;
	logic [20:0]          v;
	logic                 rej;
	logic                 err;
	logic                 brk;
	logic                 ok;
	logic [2:0]           used;
	logic [2:0]           rn;
	logic                 rcont;
	logic                 rbreak;
	logic                 eval;
	logic                 emit;
	logic                 go;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			w[i] = q_q[i];
		end
		wn   = qn_q;
		wend = end_q;
		if (!busy_q) begin
			w[qn_q[1:0]] = cls_word.b;
			wn           = qn_q + 3'd1;
			wend         = cls_word.eos;
		end
		eval = busy_q || !cls_empty;

		n     = w[0].len;
		avail = (wn < n) ? wn : n;
		bad   = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if (3'(i) < avail && !u8sd_pkg::is_cont(w[i].data)) begin
				bad = 1'b1;
			end
		end

		case (n)
			u8sd_pkg::LEN_TWO: begin
				v   = {10'd0, w[0].data[4:0], w[1].data[5:0]};
				rej = v < u8sd_pkg::CP_MIN2;
			end
			u8sd_pkg::LEN_THREE: begin
				v   = {5'd0, w[0].data[3:0], w[1].data[5:0], w[2].data[5:0]};
				rej = v < u8sd_pkg::CP_MIN3
					|| (v >= u8sd_pkg::SURR_LO && v < u8sd_pkg::SURR_END)
					|| (v >= u8sd_pkg::NONCHAR_LO && v <= u8sd_pkg::NONCHAR_HI)
					|| (v & u8sd_pkg::NONCHAR_MASK) == u8sd_pkg::NONCHAR_MASK;
			end
			u8sd_pkg::LEN_FOUR: begin
				v   = {w[0].data[2:0], w[1].data[5:0], w[2].data[5:0], w[3].data[5:0]};
				rej = v < u8sd_pkg::CP_MIN4 || v >= u8sd_pkg::CP_LIMIT
					|| (v & u8sd_pkg::NONCHAR_MASK) == u8sd_pkg::NONCHAR_MASK;
			end
			default: begin
				v   = {13'd0, w[0].data};
				rej = 1'b0;
			end
		endcase

		err = 1'b0;
		brk = 1'b0;
		ok  = 1'b0;
		if (n == u8sd_pkg::LEN_NONE) begin
			err = 1'b1;
		end else if (n != u8sd_pkg::LEN_ONE) begin
			if (bad) begin
				err = 1'b1;
			end else if (wn < n) begin
				if (!wend) begin
					brk = 1'b1;
				end else begin
					err = 1'b1;
				end
			end else if (rej) begin
				err = 1'b1;
			end else begin
				ok = 1'b1;
			end
		end
		used = ok ? n : u8sd_pkg::LEN_ONE;

		rn = wn - used;
		for (int i = 0; i < 3; i++) begin
			r[i] = w[2'(i + int'(used))];
		end
		rcont = 1'b1;
		for (int i = 1; i < 3; i++) begin
			if (3'(i) < rn && !u8sd_pkg::is_cont(r[i].data)) begin
				rcont = 1'b0;
			end
		end
		rbreak = (rn == 3'd0)
			|| (!wend && r[0].len > u8sd_pkg::LEN_ONE && rn < r[0].len && rcont);

		emit     = eval && !brk;
		go       = eval && (brk || !out_full);
		out_push = emit && !out_full;
		cls_pop  = go && !busy_q;

		out_word.code_point  = ok ? v : {13'd0, w[0].data};
		out_word.is_error    = err;
		out_word.byte_length = used;
		out_word.last_of_run = rbreak;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (brk) begin
				for (int i = 0; i < 4; i++) begin
					q_q[i] <= w[i];
				end
			end else begin
				for (int i = 0; i < 3; i++) begin
					q_q[i] <= r[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q   <= '0;
			end_q  <= 1'b0;
			busy_q <= 1'b0;
		end else if (go) begin
			if (brk) begin
				qn_q   <= wn;
				busy_q <= 1'b0;
			end else begin
				qn_q   <= rn;
				busy_q <= !rbreak;
			end
			end_q <= wend;
		end
	end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the UTF-8 stream decoder: byte stimulus, code point prediction.
`timescale 1ns / 1ps

class cp_board;
	u8sd_pkg::out_word_t exp_cps [$];
	logic [7:0] held [3];
	int held_cnt;
	int errs;

	function new();
		held_cnt = 0;
		errs = 0;
	endfunction

	function void note_byte(u8sd_pkg::in_word_t w);
		logic [7:0] q [4];
		int qn, n, used, avail, k, nres;
		logic [20:0] cp, v;
		bit err, bad, wait_more, rej;
		u8sd_pkg::out_word_t r;
		for (k = 0; k < held_cnt; k++) q[k] = held[k];
		qn = held_cnt;
		q[qn] = w.data_byte;
		qn++;
		nres = 0;
		wait_more = 1'b0;
		while (qn > 0 && !wait_more) begin
			casez (q[0])
				8'b0???????: n = 1;
				8'b110?????: n = 2;
				8'b1110????: n = 3;
				8'b11110???: n = 4;
				default: n = 0;
			endcase
			cp = {13'd0, q[0]};
			err = 1'b0;
			used = 1;
			if (n == 0) begin
				err = 1'b1;
			end else if (n > 1) begin
				avail = (qn < n) ? qn : n;
				bad = 1'b0;
				for (k = 1; k < avail; k++) if (q[k][7:6] != 2'b10) bad = 1'b1;
				if (bad) begin
					err = 1'b1;
				end else if (qn < n) begin
					if (w.end_of_string) err = 1'b1;
					else wait_more = 1'b1;
				end else begin
					case (n)
						2: v = {10'd0, q[0][4:0], q[1][5:0]};
						3: v = {5'd0, q[0][3:0], q[1][5:0], q[2][5:0]};
						default: v = {q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
					endcase
					if (n == 2)
						rej = v < u8sd_pkg::CP_MIN2;
					else if (n == 3)
						rej = v < u8sd_pkg::CP_MIN3 ||
							(v >= u8sd_pkg::SURR_LO && v < u8sd_pkg::SURR_END) ||
							(v >= u8sd_pkg::NONCHAR_LO && v <= u8sd_pkg::NONCHAR_HI) ||
							(v & u8sd_pkg::NONCHAR_MASK) == u8sd_pkg::NONCHAR_MASK;
					else
						rej = v < u8sd_pkg::CP_MIN4 || v >= u8sd_pkg::CP_LIMIT ||
							(v & u8sd_pkg::NONCHAR_MASK) == u8sd_pkg::NONCHAR_MASK;
					if (rej) begin
						err = 1'b1;
					end else begin
						cp = v;
						used = n;
					end
				end
			end
			if (!wait_more) begin
				r.code_point = cp;
				r.is_error = err;
				r.byte_length = 3'(used);
				r.last_of_run = 1'b0;
				exp_cps.push_back(r);
				nres++;
				for (k = used; k < qn; k++) q[k - used] = q[k];
				qn -= used;
			end
		end
		for (k = 0; k < qn; k++) held[k] = q[k];
		held_cnt = qn;
		if (nres > 0) begin
			r = exp_cps.pop_back();
			r.last_of_run = 1'b1;
			exp_cps.push_back(r);
		end
	endfunction

	function void check_cp(u8sd_pkg::out_word_t got);
		u8sd_pkg::out_word_t e;
		if (exp_cps.size() == 0) begin
			$error("result with nothing expected: code_point %0h", got.code_point);
			errs++;
			return;
		end
		e = exp_cps.pop_front();
		if (got.code_point !== e.code_point) begin
			$error("code_point expected %0h actual %0h", e.code_point, got.code_point);
			errs++;
		end
		if (got.is_error !== e.is_error) begin
			$error("is_error expected %0h actual %0h", e.is_error, got.is_error);
			errs++;
		end
		if (got.byte_length !== e.byte_length) begin
			$error("byte_length expected %0h actual %0h", e.byte_length, got.byte_length);
			errs++;
		end
		if (got.last_of_run !== e.last_of_run) begin
			$error("last_of_run expected %0h actual %0h", e.last_of_run, got.last_of_run);
			errs++;
		end
	endfunction
endclass

module tb_top;
	localparam int RAND_ITEMS   = 320;
	localparam int LONG_HOLD    = 150;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	u8sd_pkg::in_word_t item = '0;
	u8sd_pkg::out_word_t result;

	cp_board board;
	int n_sent = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit rx_hold_req = 1'b0;

	utf8_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit eos);
		int gap;
		u8sd_pkg::in_word_t w;
		w.data_byte = b;
		w.end_of_string = eos;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		board.note_byte(w);
		n_sent++;
	endtask

	task automatic send_seq(input logic [31:0] bytes, input int n, input bit eos_last);
		int i;
		for (i = n - 1; i >= 0; i--) send_byte(bytes[8*i +: 8], eos_last && i == 0);
	endtask

	task automatic drain_wait();
		do @(posedge clk); while (board.exp_cps.size() != 0);
	endtask

	task automatic send_random_run();
		int kind, len, i;
		logic [20:0] cp;
		logic [31:0] rnd;
		logic [7:0] b [4];
		bit eos;
		kind = $urandom_range(0, 9);
		rnd = $urandom;
		if (kind < 2) begin
			len = 1;
			b[0] = rnd[7:0];
		end else if (kind < 6) begin
			case ($urandom_range(0, 3))
				0: begin cp = 21'($urandom_range(0, 'h7f)); len = 1; end
				1: begin cp = 21'($urandom_range('h80, 'h7ff)); len = 2; end
				2: begin cp = 21'($urandom_range('h800, 'hffff)); len = 3; end
				default: begin cp = 21'($urandom_range('h10000, 'h10ffff)); len = 4; end
			endcase
			case (len)
				1: b[0] = cp[7:0];
				2: begin
					b[0] = {3'b110, cp[10:6]};
					b[1] = {2'b10, cp[5:0]};
				end
				3: begin
					b[0] = {4'b1110, cp[15:12]};
					b[1] = {2'b10, cp[11:6]};
					b[2] = {2'b10, cp[5:0]};
				end
				default: begin
					b[0] = {5'b11110, cp[20:18]};
					b[1] = {2'b10, cp[17:12]};
					b[2] = {2'b10, cp[11:6]};
					b[3] = {2'b10, cp[5:0]};
				end
			endcase
		end else begin
			len = $urandom_range(2, 4);
			case (len)
				2: b[0] = {3'b110, rnd[4:0]};
				3: b[0] = {4'b1110, rnd[3:0]};
				default: b[0] = {5'b11110, rnd[2:0]};
			endcase
			for (i = 1; i < len; i++) b[i] = {2'b10, rnd[6*i +: 6]};
			if ($urandom_range(0, 7) == 0) b[$urandom_range(1, len - 1)] = 8'($urandom);
		end
		for (i = 0; i < len; i++) begin
			if (i == len - 1) eos = $urandom_range(0, 5) == 0;
			else eos = $urandom_range(0, 15) == 0;
			send_byte(b[i], eos);
		end
	endtask

	initial begin
		int start;
		bit held_once, paused_once;
		board = new();
		held_once = 1'b0;
		paused_once = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_seq(32'h00, 1, 1'b1);
		send_seq(32'hC280, 2, 1'b0);
		send_seq(32'hC1BF, 2, 1'b0);
		send_seq(32'hEDA080, 3, 1'b0);
		send_seq(32'hEFB790, 3, 1'b0);
		send_seq(32'hEFBFBF, 3, 1'b0);
		send_seq(32'hF4908080, 4, 1'b0);
		send_seq(32'hF0908041, 4, 1'b0);
		send_seq(32'hFF, 1, 1'b0);
		send_seq(32'hE241, 2, 1'b0);
		send_seq(32'hF090, 2, 1'b1);
		push <= 1'b0;
		drain_wait();

		start = n_sent;
		while (n_sent < start + RAND_ITEMS) begin
			no_idle = (n_sent >= start + 120) && (n_sent < start + 170);
			if (!held_once && n_sent >= start + 60) begin
				rx_hold_req = 1'b1;
				held_once = 1'b1;
			end
			if (!paused_once && n_sent >= start + 200) begin
				push <= 1'b0;
				drain_wait();
				paused_once = 1'b1;
			end
			send_random_run();
		end
		push <= 1'b0;
		no_idle = 1'b0;

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errs == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_hold_req = 1'b0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			board.check_cp(result);
		end
	end
endmodule

// File: utf8_stream_decoder.f
rtl/u8sd_pkg.sv
rtl/u8sd_fifo.sv
rtl/u8sd_front.sv
rtl/u8sd_back.sv
rtl/utf8_stream_decoder.sv
sim/tb_top.sv
